>>> sv/tsma_pkg.sv
// Shared constants and types for the two-stage moving average block.
// No dependencies; every other file in this folder imports it.
package tsma_pkg;

  localparam int SAMPLE_W        = 12;
  localparam int WINDOW_DEPTH    = 64;
  localparam int WIN_POS_W       = $clog2(WINDOW_DEPTH);
  localparam int WIN_SUM_W       = SAMPLE_W + WIN_POS_W;
  localparam int UPDATE_INTERVAL = 4;
  localparam int BLOCK_DEPTH     = 4;
  localparam int BLK_SHIFT       = $clog2(BLOCK_DEPTH);
  localparam int BLK_SUM_W       = SAMPLE_W + BLK_SHIFT;

  // output buffer: two words, so a finished word can wait while the next is taken
  localparam int OBUF_DEPTH = 2;
  localparam int OBUF_PTR_W = $clog2(OBUF_DEPTH);
  localparam int OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;

  localparam logic [WIN_POS_W-1:0] WIN_POS_LAST = WIN_POS_W'(WINDOW_DEPTH - 1);
  localparam logic [WIN_POS_W-1:0] UPD_MASK     = WIN_POS_W'(UPDATE_INTERVAL - 1);

  // one sample pair, channel a in the low bits
  typedef struct packed {
    logic [SAMPLE_W-1:0] b;
    logic [SAMPLE_W-1:0] a;
  } pair_t;

  // one result word as held in the output buffer
  typedef struct packed {
    logic                slow_updated;
    logic                fast_updated;
    logic [SAMPLE_W-1:0] slow_avg_b;
    logic [SAMPLE_W-1:0] slow_avg_a;
    logic [SAMPLE_W-1:0] fast_avg_b;
    logic [SAMPLE_W-1:0] fast_avg_a;
  } result_t;

endpackage

>>> sv/two_stage_moving_average_top.sv
// Top level of the two-stage moving average: window and block shift chains,
// running sums and the output buffer. Depends on tsma_pkg, tsma_cell, tsma_out_fifo.
//
// channel  | group                           | contents
// ---------+---------------------------------+----------------------------------------
// input    | in_tvalid/in_tready/in_tdata    | sample_a, sample_b
// output   | out_tvalid/out_tready/out_tdata | fast/slow averages a and b, two flags
//
// One word per cycle is taken while in_tready is high; its result is registered in the output buffer.
// The 64-cell window chain and the running sums are updated in the accepting cycle.
// A two-word output buffer lets input continue while one result waits.
// in_tready drops only when both buffer words are held by a stalled consumer.
// Synchronous reset clears the window, the block store and all held averages.
module two_stage_moving_average_top
  import tsma_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [11:0] sample_a, [23:12] sample_b
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [11:0] fast_avg_a, [23:12] fast_avg_b,
                                            // [35:24] slow_avg_a, [47:36] slow_avg_b,
                                            // [48] fast_updated, [49] slow_updated, rest 0
);

  logic                 acc;
  pair_t                sample;
  pair_t                win_q [WINDOW_DEPTH];
  pair_t                win_d [WINDOW_DEPTH];
  pair_t                oldest;
  pair_t                blk_q [BLOCK_DEPTH-1];
  pair_t                blk_d [BLOCK_DEPTH-1];
  logic [WIN_SUM_W-1:0] sum_a_r, sum_b_r, sum_a_nxt, sum_b_nxt;
  logic [WIN_POS_W-1:0] pos_r;
  pair_t                fast_r, fast_nxt;
  pair_t                slow_r, slow_nxt;
  logic [BLK_SUM_W-1:0] bsum_a, bsum_b;
  logic                 fast_hit;
  logic                 wrap;
  result_t              res;
  result_t              out_word;

  assign acc    = in_tvalid && in_tready;
  assign sample = pair_t'(in_tdata);

  // window chain: the last cell holds the pair written one window ago
  assign win_d[0] = sample;
  genvar gi;
  generate
    for (gi = 1; gi < WINDOW_DEPTH; gi++) begin : g_win_link
      assign win_d[gi] = win_q[gi-1];
    end
    for (gi = 0; gi < WINDOW_DEPTH; gi++) begin : g_win
      tsma_cell u_win_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (acc),
        .d        (win_d[gi]),
        .q        (win_q[gi])
      );
    end
  endgenerate
  assign oldest = win_q[WINDOW_DEPTH-1];

  // running window sums
  assign sum_a_nxt = sum_a_r - WIN_SUM_W'(oldest.a) + WIN_SUM_W'(sample.a);
  assign sum_b_nxt = sum_b_r - WIN_SUM_W'(oldest.b) + WIN_SUM_W'(sample.b);

  assign fast_hit = ((pos_r & UPD_MASK) == '0);
  assign wrap     = (pos_r == WIN_POS_LAST);

  always_comb begin
    fast_nxt = fast_r;
    if (fast_hit) begin
      fast_nxt.a = sum_a_nxt[WIN_POS_W +: SAMPLE_W];
      fast_nxt.b = sum_b_nxt[WIN_POS_W +: SAMPLE_W];
    end
  end

  // block store chain: the newest fast average enters on wrap; together with the
  // entry being written, these cells hold the whole block store
  assign blk_d[0] = fast_nxt;
  generate
    for (gi = 1; gi < BLOCK_DEPTH - 1; gi++) begin : g_blk_link
      assign blk_d[gi] = blk_q[gi-1];
    end
    for (gi = 0; gi < BLOCK_DEPTH - 1; gi++) begin : g_blk
      tsma_cell u_blk_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (acc && wrap),
        .d        (blk_d[gi]),
        .q        (blk_q[gi])
      );
    end
  endgenerate

  // block mean over the new entry and the newest stored ones
  always_comb begin
    bsum_a = BLK_SUM_W'(fast_nxt.a);
    bsum_b = BLK_SUM_W'(fast_nxt.b);
    for (int k = 0; k < BLOCK_DEPTH - 1; k++) begin
      bsum_a = bsum_a + BLK_SUM_W'(blk_q[k].a);
      bsum_b = bsum_b + BLK_SUM_W'(blk_q[k].b);
    end
    slow_nxt.a = bsum_a[BLK_SHIFT +: SAMPLE_W];
    slow_nxt.b = bsum_b[BLK_SHIFT +: SAMPLE_W];
  end

  // held state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_a_r <= '0;
      sum_b_r <= '0;
      pos_r   <= '0;
      fast_r  <= '0;
      slow_r  <= '0;
    end else if (acc) begin
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      pos_r   <= pos_r + 1'b1;
      fast_r  <= fast_nxt;
      if (wrap) begin
        slow_r <= slow_nxt;
      end
    end
  end

  // result word for this item
  always_comb begin
    res.fast_avg_a   = fast_nxt.a;
    res.fast_avg_b   = fast_nxt.b;
    res.slow_avg_a   = wrap ? slow_nxt.a : slow_r.a;
    res.slow_avg_b   = wrap ? slow_nxt.b : slow_r.b;
    res.fast_updated = fast_hit;
    res.slow_updated = wrap;
  end

  tsma_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_tvalid),
    .wr_ready (in_tready),
    .wr_data  (res),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (out_word)
  );

  assign out_tdata = OUT_DATA_W'(out_word);

`ifndef ASSERT_OFF
  // the window position returns to zero after the last slot
  a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    acc && wrap |=> pos_r == '0)
    else $error("window position did not wrap");

  // the last slot never falls on a fast update, so both flags never meet
  a_flags_apart: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_word.slow_updated && out_word.fast_updated))
    else $error("fast and slow update flagged together");

  // an accepted item always leaves a result to offer
  a_acc_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_tvalid)
    else $error("accepted item produced no result");
`endif

endmodule

>>> sv/tsma_cell.sv
// One storage cell of a shift chain: holds a sample pair, loads its neighbor's.
// Depends on tsma_pkg.
module tsma_cell
  import tsma_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift_en,
  input  pair_t d,
  output pair_t q
);

  pair_t q_r;

  // contents are part of the averaged state, so reset clears them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift_en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

>>> sv/tsma_out_fifo.sv
// Small output buffer for result words; decouples acceptance from the consumer.
// Depends on tsma_pkg.
module tsma_out_fifo
  import tsma_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_valid,
  output logic    wr_ready,
  input  result_t wr_data,
  output logic    rd_valid,
  input  logic    rd_ready,
  output result_t rd_data
);

  result_t                mem_r [OBUF_DEPTH];
  logic [OBUF_PTR_W-1:0]  wr_ptr_r;
  logic [OBUF_PTR_W-1:0]  rd_ptr_r;
  logic [OBUF_CNT_W-1:0]  cnt_r;
  logic [OBUF_CNT_W-1:0]  cnt_nxt;
  logic                   do_wr;
  logic                   do_rd;

  assign wr_ready = (cnt_r != OBUF_CNT_W'(OBUF_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> test/tb_two_stage_moving_average_top.sv
// Self-checking testbench for two_stage_moving_average_top: bursty sample words in,
// randomly stalled result words out, every result checked against a local predictor.
// Depends on tsma_pkg and the two_stage_moving_average_top RTL.
`timescale 1ns / 1ps

module tb_two_stage_moving_average_top;
  import tsma_pkg::*;

  localparam int RANDOM_WORDS = 1950;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 20;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;

  // Predictor of the window and block averages plus the queue of expected words
  class average_tracker;
    logic [SAMPLE_W-1:0]  win_a [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0]  win_b [WINDOW_DEPTH];
    logic [WIN_SUM_W-1:0] sum_a, sum_b;
    logic [WIN_POS_W-1:0] win_pos;
    logic [SAMPLE_W-1:0]  fast_a, fast_b;
    logic [SAMPLE_W-1:0]  blk_a [BLOCK_DEPTH];
    logic [SAMPLE_W-1:0]  blk_b [BLOCK_DEPTH];
    logic [BLK_SHIFT-1:0] blk_pos;
    logic [SAMPLE_W-1:0]  slow_a, slow_b;
    result_t              expected_words [$];
    int unsigned          mismatches, checked, fast_updates, slow_updates;

    function new();
      foreach (win_a[i]) begin
        win_a[i] = '0;
        win_b[i] = '0;
      end
      foreach (blk_a[i]) begin
        blk_a[i] = '0;
        blk_b[i] = '0;
      end
      sum_a = '0;
      sum_b = '0;
      win_pos = '0;
      blk_pos = '0;
      fast_a = '0;
      fast_b = '0;
      slow_a = '0;
      slow_b = '0;
      mismatches = 0;
      checked = 0;
      fast_updates = 0;
      slow_updates = 0;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    // advance the averages by one accepted sample word
    function void note_pair(pair_t p);
      result_t r;
      logic [BLK_SUM_W-1:0] bsum_a, bsum_b;
      r = '0;
      sum_a = sum_a - win_a[win_pos] + p.a;
      sum_b = sum_b - win_b[win_pos] + p.b;
      win_a[win_pos] = p.a;
      win_b[win_pos] = p.b;
      if (win_pos % UPDATE_INTERVAL == 0) begin
        fast_a = SAMPLE_W'(sum_a / WINDOW_DEPTH);
        fast_b = SAMPLE_W'(sum_b / WINDOW_DEPTH);
        r.fast_updated = 1'b1;
      end
      // window wrap: store the fast average as held (no fast update falls on the wrap) into the block store
      if (win_pos == WINDOW_DEPTH - 1) begin
        blk_a[blk_pos] = fast_a;
        blk_b[blk_pos] = fast_b;
        bsum_a = '0;
        bsum_b = '0;
        foreach (blk_a[i]) begin
          bsum_a = bsum_a + blk_a[i];
          bsum_b = bsum_b + blk_b[i];
        end
        slow_a = SAMPLE_W'(bsum_a / BLOCK_DEPTH);
        slow_b = SAMPLE_W'(bsum_b / BLOCK_DEPTH);
        r.slow_updated = 1'b1;
        blk_pos = blk_pos + 1'b1;
      end
      win_pos = win_pos + 1'b1;
      r.fast_avg_a = fast_a;
      r.fast_avg_b = fast_b;
      r.slow_avg_a = slow_a;
      r.slow_avg_b = slow_b;
      expected_words.push_back(r);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    // compare one accepted result word with the oldest expectation
    function void check_word(logic [OUT_DATA_W-1:0] w);
      result_t want, got;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result word, expected none, actual %h", $time, w);
        return;
      end
      want = expected_words.pop_front();
      got = w[$bits(result_t)-1:0];
      checked++;
      if (want.fast_updated) fast_updates++;
      if (want.slow_updated) slow_updates++;
      compare_field("fast_avg_a", want.fast_avg_a, got.fast_avg_a);
      compare_field("fast_avg_b", want.fast_avg_b, got.fast_avg_b);
      compare_field("slow_avg_a", want.slow_avg_a, got.slow_avg_a);
      compare_field("slow_avg_b", want.slow_avg_b, got.slow_avg_b);
      compare_field("fast_updated", want.fast_updated, got.fast_updated);
      compare_field("slow_updated", want.slow_updated, got.slow_updated);
      compare_field("padding", 0, w[OUT_DATA_W-1:$bits(result_t)]);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;    // [11:0] sample_a, [23:12] sample_b
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;   // [11:0] fast_avg_a, [23:12] fast_avg_b,
                                      // [35:24] slow_avg_a, [47:36] slow_avg_b,
                                      // [48] fast_updated, [49] slow_updated

  average_tracker tracker = new();
  bit             drained = 1'b0;
  int             burst_left = 0;

  two_stage_moving_average_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // offer one sample word and hold it until the block takes it
  task automatic send_pair(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b);
    pair_t p;
    p.a = a;
    p.b = b;
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    do @(posedge clk); while (!in_tready);
    // bursts of random length, then a random gap (zero gap keeps streaming)
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 60);
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // receiver ready pattern: changes character after each stretch of random length
  initial begin
    int  mode, left, hold, phase;
    bit  rdy;
    out_tready = 1'b0;
    left = 0;
    hold = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(50, 300);
      end
      left--;
      phase++;
      case (mode)
        0: begin
          rdy = 1'b1;
        end
        1: begin
          rdy = bit'($urandom_range(0, 1));
        end
        2: begin
          rdy = (phase % 3 == 0);
        end
        default: begin
          if (hold > 0) begin
            hold--;
            rdy = 1'b0;
          end else if ($urandom_range(0, 9) == 0) begin
            hold = $urandom_range(5, 20);
            rdy = 1'b0;
          end else begin
            rdy = 1'b1;
          end
        end
      endcase
      out_tready <= rdy;
    end
  end

  // observe both handshakes; input noted first so a same-edge result finds its entry
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) tracker.note_pair(in_tdata);
      if (out_tvalid && out_tready) tracker.check_word(out_tdata);
    end
  end

  // watchdog: too many cycles with no word moving on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || drained || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no word accepted for %0d cycles, %0d results outstanding",
             $time, QUIET_LIMIT, tracker.pending());
    $display("Regression FAIL");
    $finish;
  end

  // stimulus
  initial begin
    logic [SAMPLE_W-1:0] a, b;
    int mode, seg_left, sent;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    rst_n     = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, checkerboards, walking ones against walking zeros
    send_pair('0, '0);
    send_pair(FULL_SCALE, FULL_SCALE);
    send_pair('0, FULL_SCALE);
    send_pair(FULL_SCALE, '0);
    send_pair(12'hAAA, 12'h555);
    send_pair(12'h555, 12'hAAA);
    send_pair(12'h001, 12'h800);
    send_pair(12'h800, 12'h001);
    for (int k = 0; k < SAMPLE_W; k++) begin
      a = SAMPLE_W'(1) << k;
      send_pair(a, ~a);
    end

    // random segments; constant runs are at least one window long
    seg_left = 0;
    mode = 0;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if (seg_left == 0) begin
        mode = $urandom_range(0, 9);
        seg_left = (mode < 5) ? $urandom_range(20, 200) : $urandom_range(64, 320);
      end
      seg_left--;
      case (mode)
        5: begin
          a = FULL_SCALE;
          b = FULL_SCALE;
        end
        6: begin
          a = '0;
          b = '0;
        end
        7: begin
          a = SAMPLE_W'($urandom_range(4000, 4095));
          b = SAMPLE_W'($urandom_range(0, 95));
        end
        8: begin
          a = SAMPLE_W'($urandom_range(0, 15));
          b = SAMPLE_W'($urandom_range(0, 15));
        end
        9: begin
          a = $urandom_range(0, 1) ? FULL_SCALE : '0;
          b = $urandom_range(0, 1) ? FULL_SCALE : '0;
        end
        default: begin
          a = SAMPLE_W'($urandom_range(0, 4095));
          b = SAMPLE_W'($urandom_range(0, 4095));
        end
      endcase
      send_pair(a, b);
      sent++;
    end
    in_tvalid <= 1'b0;

    // drain, then keep watching for stray words
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    drained = 1'b1;

    $display("Checked %0d result words (%0d fast and %0d slow average updates).",
             tracker.checked, tracker.fast_updates, tracker.slow_updates);
    $display("Stimulus mixed random, full-scale and zero runs with input gaps and output stalls.");
    if (tracker.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> files.f
sv/tsma_pkg.sv
sv/tsma_cell.sv
sv/tsma_out_fifo.sv
sv/two_stage_moving_average_top.sv
test/tb_two_stage_moving_average_top.sv
